/* rtl/tch_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Shared widths, constants and the arctangent table for the CORDIC cells.
// ----------------------------------------------------------------------------
package tch_pkg;

   localparam int TableLen = 24;
   localparam int AngW     = 40;   // angle accumulator, 2^-20 degree
   localparam int RotW     = 34;   // rotation CORDIC datapath, Q30 plus guard
   localparam int VecW     = 56;   // vectoring CORDIC datapath
   localparam int FullTurn = 23040;

   localparam logic signed [AngW-1:0] Deg180 = AngW'(64'sd188743680);
   localparam logic signed [RotW-1:0] InvGain = RotW'(64'sd652032874);

   function automatic logic signed [AngW-1:0] atan_entry(input int idx);
      logic signed [AngW-1:0] r;
      begin
         case (idx)
            0: r = 40'sd47185920;
            1: r = 40'sd27855475;
            2: r = 40'sd14718068;
            3: r = 40'sd7471121;
            4: r = 40'sd3750058;
            5: r = 40'sd1876857;
            6: r = 40'sd938658;
            7: r = 40'sd469357;
            8: r = 40'sd234682;
            9: r = 40'sd117342;
            10: r = 40'sd58671;
            11: r = 40'sd29335;
            12: r = 40'sd14668;
            13: r = 40'sd7334;
            14: r = 40'sd3667;
            15: r = 40'sd1833;
            16: r = 40'sd917;
            17: r = 40'sd458;
            18: r = 40'sd229;
            19: r = 40'sd115;
            20: r = 40'sd57;
            21: r = 40'sd29;
            22: r = 40'sd14;
            23: r = 40'sd7;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

/* rtl/tch_rot_cell.sv */
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One micro-rotation of a sine/cosine CORDIC, registered, with enable.
// ----------------------------------------------------------------------------
module tch_rot_cell
   import tch_pkg::*;
#(
   parameter int Shift = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [RotW-1:0] x_in,
   input  logic signed [RotW-1:0] y_in,
   input  logic signed [AngW-1:0] z_in,
   output logic signed [RotW-1:0] x_out,
   output logic signed [RotW-1:0] y_out,
   output logic signed [AngW-1:0] z_out
);

   logic signed [RotW-1:0] x_ff, y_ff, x_in_s, y_in_s;
   logic signed [AngW-1:0] z_ff, z_nx;

   always_comb begin
      if (z_in >= 0) begin
         x_in_s = x_in - (y_in >>> Shift);
         y_in_s = y_in + (x_in >>> Shift);
         z_nx   = z_in - atan_entry(Shift);
      end else begin
         x_in_s = x_in + (y_in >>> Shift);
         y_in_s = y_in - (x_in >>> Shift);
         z_nx   = z_in + atan_entry(Shift);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in_s;
         y_ff <= y_in_s;
         z_ff <= z_nx;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

/* rtl/tch_vec_cell.sv */
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation driving y toward zero, accumulating the angle.
// ----------------------------------------------------------------------------
module tch_vec_cell
   import tch_pkg::*;
#(
   parameter int Shift = 0
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [VecW-1:0] x_in,
   input  logic signed [VecW-1:0] y_in,
   input  logic signed [AngW-1:0] z_in,
   input  logic                   tag_in,
   output logic signed [VecW-1:0] x_out,
   output logic signed [VecW-1:0] y_out,
   output logic signed [AngW-1:0] z_out,
   output logic                   tag_out
);

   logic signed [VecW-1:0] x_ff, y_ff, x_nx, y_nx;
   logic signed [AngW-1:0] z_ff, z_nx;
   logic                   tag_ff;

   always_comb begin
      if (y_in >= 0) begin
         x_nx = x_in + (y_in >>> Shift);
         y_nx = y_in - (x_in >>> Shift);
         z_nx = z_in + atan_entry(Shift);
      end else begin
         x_nx = x_in - (y_in >>> Shift);
         y_nx = y_in + (x_in >>> Shift);
         z_nx = z_in - atan_entry(Shift);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff   <= x_nx;
         y_ff   <= y_nx;
         z_ff   <= z_nx;
         tag_ff <= tag_in;
      end
   end

   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;
   assign tag_out = tag_ff;

endmodule

/* rtl/tilt_compensated_heading_core.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading core
// Sine/cosine by a row of rotation cells, tilt compensation by two multiply
// stages, heading by a row of vectoring cells, rounded and wrapped to 0..360.
// ----------------------------------------------------------------------------
// Path: prep, NSt rotation cells, round, two multiply stages, vectoring prep,
// NSt vectoring cells, output; NSt is CORDIC_STAGES clamped to 24.
// Throughput: one request per cycle; the whole pipe advances together and
// stalls only when the response register is full and not taken.
// Reset: synchronous, active high; clears the valid bits of every stage.
// Payload registers are not reset.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_core
   import tch_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // field_x [15:0], field_y [31:16], field_z [47:32], roll_angle [62:48],
   // pitch_angle [77:63], zero fill [79:78]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // heading_angle [14:0], zero fill [15]
   output logic [15:0] rsp_tdata
);

   localparam int NSt = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
   // stages: 1 prep, NSt rot, 1 round, 1 mul1, 1 mul2, 1 vec prep, NSt vec, 1 out
   localparam int Depth = 2 * NSt + 6;

   // The pipe moves whenever the output slot is free or being emptied.
   logic advance;
   logic [Depth-1:0] vld_ff, vld_in;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_tvalid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end
   assign rsp_tvalid = vld_ff[Depth-1];

   // ---------------- input unpack and angle folding ----------------
   logic signed [15:0] fx, fy, fz;
   logic signed [14:0] ra, pa;
   assign fx = req_tdata[15:0];
   assign fy = req_tdata[31:16];
   assign fz = req_tdata[47:32];
   assign ra = req_tdata[62:48];
   assign pa = req_tdata[77:63];

   // Fold an angle into +-90 degrees; report whether sin/cos must be negated.
   function automatic logic signed [AngW-1:0] fold(input logic signed [14:0] a,
                                                   output logic neg);
      logic signed [16:0] w;
      begin
         w = 17'(a);
         neg = 1'b0;
         if (w > 17'sd11520) w = w - 17'sd23040;
         else if (w < -17'sd11520) w = w + 17'sd23040;
         if (w > 17'sd5760) begin
            w = w - 17'sd11520;
            neg = 1'b1;
         end else if (w < -17'sd5760) begin
            w = w + 17'sd11520;
            neg = 1'b1;
         end
         return AngW'(w) <<< 14;
      end
   endfunction

   logic signed [AngW-1:0] rz0_ff, pz0_ff, rz_c, pz_c;
   logic rneg_c, pneg_c;
   logic signed [15:0] fx0_ff, fy0_ff, fz0_ff;
   logic rneg0_ff, pneg0_ff;

   always_comb begin
      rz_c = fold(ra, rneg_c);
      pz_c = fold(pa, pneg_c);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rz0_ff <= rz_c; pz0_ff <= pz_c;
         rneg0_ff <= rneg_c; pneg0_ff <= pneg_c;
         fx0_ff <= fx; fy0_ff <= fy; fz0_ff <= fz;
      end
   end

   // ---------------- rotation cell rows (roll and pitch) ----------------
   logic signed [RotW-1:0] rx [NSt+1], ry [NSt+1], px [NSt+1], py [NSt+1];
   logic signed [AngW-1:0] rzz [NSt+1], pzz [NSt+1];
   assign rx[0] = InvGain; assign ry[0] = '0; assign rzz[0] = rz0_ff;
   assign px[0] = InvGain; assign py[0] = '0; assign pzz[0] = pz0_ff;

   // Side data travels through a plain delay line beside the cells.
   logic signed [15:0] dfx_ff [NSt], dfy_ff [NSt], dfz_ff [NSt];
   logic dr_ff [NSt], dp_ff [NSt];

   for (genvar g = 0; g < NSt; g++) begin : g_rot
      tch_rot_cell #(.Shift(g)) u_r (
         .clock(clock), .enable(advance),
         .x_in(rx[g]), .y_in(ry[g]), .z_in(rzz[g]),
         .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rzz[g+1]));
      tch_rot_cell #(.Shift(g)) u_p (
         .clock(clock), .enable(advance),
         .x_in(px[g]), .y_in(py[g]), .z_in(pzz[g]),
         .x_out(px[g+1]), .y_out(py[g+1]), .z_out(pzz[g+1]));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dfx_ff[0] <= fx0_ff; dfy_ff[0] <= fy0_ff; dfz_ff[0] <= fz0_ff;
         dr_ff[0] <= rneg0_ff; dp_ff[0] <= pneg0_ff;
         for (int k = 1; k < NSt; k++) begin
            dfx_ff[k] <= dfx_ff[k-1]; dfy_ff[k] <= dfy_ff[k-1];
            dfz_ff[k] <= dfz_ff[k-1];
            dr_ff[k] <= dr_ff[k-1]; dp_ff[k] <= dp_ff[k-1];
         end
      end
   end

   // ---------------- round to Q15 and apply the half-turn sign ----------------
   function automatic logic signed [17:0] rnd(input logic signed [RotW-1:0] v,
                                              input logic neg);
      logic signed [RotW-1:0] t;
      logic signed [17:0] q;
      begin
         t = (v + RotW'(16384)) >>> 15;
         q = t[17:0];
         return neg ? -q : q;
      end
   endfunction

   logic signed [17:0] cr_ff, sr_ff, cp_ff, sp_ff;
   logic signed [15:0] fx1_ff, fy1_ff, fz1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cr_ff <= rnd(rx[NSt], dr_ff[NSt-1]);
         sr_ff <= rnd(ry[NSt], dr_ff[NSt-1]);
         cp_ff <= rnd(px[NSt], dp_ff[NSt-1]);
         sp_ff <= rnd(py[NSt], dp_ff[NSt-1]);
         fx1_ff <= dfx_ff[NSt-1]; fy1_ff <= dfy_ff[NSt-1]; fz1_ff <= dfz_ff[NSt-1];
      end
   end

   // ---------------- tilt compensation, two multiply stages ----------------
   // Stage one: a = y*sr + z*cr, b = x*cp, hy = y*cr - z*sr.
   // Each product is formed at its full width before it is summed.
   logic signed [33:0] ysr_c, zcr_c, xcp_c, ycr_c, zsr_c;
   assign ysr_c = fy1_ff * sr_ff;
   assign zcr_c = fz1_ff * cr_ff;
   assign xcp_c = fx1_ff * cp_ff;
   assign ycr_c = fy1_ff * cr_ff;
   assign zsr_c = fz1_ff * sr_ff;

   logic signed [34:0] a_ff, b_ff, hy1_ff;
   logic signed [17:0] sp1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff   <= 35'(ysr_c) + 35'(zcr_c);
         b_ff   <= 35'(xcp_c);
         hy1_ff <= 35'(ycr_c) - 35'(zsr_c);
         sp1_ff <= sp_ff;
      end
   end

   // Stage two: hx = a*sp + b*2^15, hy scaled by 2^15.
   logic signed [52:0] asp_c;
   assign asp_c = a_ff * sp1_ff;

   logic signed [VecW-1:0] hx2_ff, hy2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         hx2_ff <= VecW'(asp_c) + (VecW'(b_ff) <<< 15);
         hy2_ff <= VecW'(hy1_ff) <<< 15;
      end
   end

   // ---------------- vectoring prep: half-turn for negative x ----------------
   logic signed [VecW-1:0] vx [NSt+1], vy [NSt+1];
   logic signed [AngW-1:0] vz [NSt+1];
   logic vt [NSt+1];
   logic signed [VecW-1:0] vx0_ff, vy0_ff;
   logic signed [AngW-1:0] vz0_ff;
   logic zero0_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         zero0_ff <= (hx2_ff == '0) && (hy2_ff == '0);
         if (hx2_ff < 0) begin
            vx0_ff <= -hx2_ff; vy0_ff <= -hy2_ff; vz0_ff <= Deg180;
         end else begin
            vx0_ff <= hx2_ff; vy0_ff <= hy2_ff; vz0_ff <= '0;
         end
      end
   end
   assign vx[0] = vx0_ff; assign vy[0] = vy0_ff; assign vz[0] = vz0_ff;
   assign vt[0] = zero0_ff;

   for (genvar g = 0; g < NSt; g++) begin : g_vec
      tch_vec_cell #(.Shift(g)) u_v (
         .clock(clock), .enable(advance),
         .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .tag_in(vt[g]),
         .x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1]), .tag_out(vt[g+1]));
   end

   // ---------------- round to 1/64 degree and wrap ----------------
   logic signed [AngW-1:0] hr;
   logic signed [25:0] h;
   logic [14:0] head_c, head_ff;
   always_comb begin
      hr = (vz[NSt] + AngW'(8192)) >>> 14;
      h  = hr[25:0];
      if (h < 0) h = h + 26'sd23040;
      if (h >= 26'sd23040) h = h - 26'sd23040;
      if (vt[NSt] || h < 0 || h >= 26'sd23040) head_c = '0;
      else head_c = h[14:0];
   end
   always_ff @(posedge clock) begin
      if (advance) head_ff <= head_c;
   end
   assign rsp_tdata = {1'b0, head_ff};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Drives field vectors with roll and pitch through the request stream and
// checks every heading against a bit-accurate fixed-point predictor kept in
// the bench or a known table value. Directed corner cases precede random ones.
// ----------------------------------------------------------------------------
module tb_top
   import tch_pkg::*;
;

   localparam int Stages     = 16;
   localparam int Latency    = 2 * Stages + 6;
   localparam int RandomReqs = 1500;
   localparam int CycleLimit = 400000;
   localparam int HalfTurn   = 11520;
   localparam int QuarterTurn = 5760;

   typedef struct packed {
      logic signed [14:0] pitch;
      logic signed [14:0] roll;
      logic signed [15:0] fz;
      logic signed [15:0] fy;
      logic signed [15:0] fx;
   } heading_req_type;

   // One row of the directed table. A known heading of -1 means the row is
   // checked against the predictor only.
   typedef struct {
      heading_req_type req;
      int              known;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   logic [14:0] heading_queue[$];
   int          mismatches = 0;
   int          cycles = 0;

   tilt_compensated_heading_core #(.CORDIC_STAGES(Stages)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Floor shift right on a signed 64 bit value.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Rotation CORDIC: angle in 1/64 degree to cosine and sine in Q15.
   function automatic void trig_q15(longint a, output longint c, output longint s);
      longint x, y, z, t;
      bit     flip;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (a > HalfTurn) a -= FullTurn;
      else if (a < -HalfTurn) a += FullTurn;
      // Beyond a quarter turn the angle is folded back and the signs flipped.
      if (a > QuarterTurn) begin
         a -= HalfTurn;
         flip = 1'b1;
      end else if (a < -QuarterTurn) begin
         a += HalfTurn;
         flip = 1'b1;
      end
      z = a * 16384;
      for (int i = 0; i < Stages; i++) begin
         if (z >= 0) begin
            t = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= longint'(atan_entry(i));
         end else begin
            t = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += longint'(atan_entry(i));
         end
         x = t;
      end
      x = floor_shift(x + 16384, 15);
      y = floor_shift(y + 16384, 15);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [14:0] predict_heading(heading_req_type r);
      longint cr, sr, cp, sp, hx, hy, z, t, h;
      trig_q15(longint'(r.roll), cr, sr);
      trig_q15(longint'(r.pitch), cp, sp);
      hx = longint'(r.fy) * sr * sp + longint'(r.fx) * cp * 32768
         + longint'(r.fz) * cr * sp;
      hy = (longint'(r.fy) * cr - longint'(r.fz) * sr) * 32768;
      if (hx == 0 && hy == 0) return '0;
      z = 0;
      // A vector in the left half plane is turned round before vectoring.
      if (hx < 0) begin
         hx = -hx;
         hy = -hy;
         z = 188743680;
      end
      for (int i = 0; i < Stages; i++) begin
         if (hy >= 0) begin
            t = hx + floor_shift(hy, i);
            hy = hy - floor_shift(hx, i);
            z += longint'(atan_entry(i));
         end else begin
            t = hx - floor_shift(hy, i);
            hy = hy + floor_shift(hx, i);
            z -= longint'(atan_entry(i));
         end
         hx = t;
      end
      h = floor_shift(z + 8192, 14);
      if (h < 0) h += FullTurn;
      if (h >= FullTurn) h -= FullTurn;
      if (h < 0 || h >= FullTurn) h = 0;
      return h[14:0];
   endfunction

   // Random request: mostly plausible tilt, sometimes any 15 bit angle.
   function automatic heading_req_type random_req();
      heading_req_type r;
      r.fx = 16'($urandom);
      r.fy = 16'($urandom);
      r.fz = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         r.roll  = 15'($urandom);
         r.pitch = 15'($urandom);
      end else begin
         r.roll  = 15'($signed($urandom_range(0, 2 * HalfTurn)) - HalfTurn);
         r.pitch = 15'($signed($urandom_range(0, 2 * HalfTurn)) - HalfTurn);
      end
      if ($urandom_range(0, 15) == 0) begin
         r.fx = 16'($urandom_range(0, 8) - 4);
         r.fy = 16'($urandom_range(0, 8) - 4);
         r.fz = 16'($urandom_range(0, 8) - 4);
      end
      return r;
   endfunction

   // Presents one request and holds it until the core accepts it. A known
   // heading from the table is expected as typed; otherwise the predictor
   // supplies it.
   task automatic send_request(heading_req_type r, int known);
      logic [14:0] expected;
      expected = (known >= 0) ? 15'(known) : predict_heading(r);
      req_tdata  <= {2'b00, r};
      req_tvalid <= 1'b1;
      heading_queue.push_back(expected);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // The receiver stalls in runs, with quiet stretches between them.
   int stall_left;
   int calm_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
         calm_left  <= 50;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (calm_left > 0) begin
         calm_left  <= calm_left - 1;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 63) == 0) calm_left <= $urandom_range(20, 80);
      end
   end

   // Compares each accepted response with the oldest expected heading.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (heading_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: heading %0d", rsp_tdata[14:0]);
         end else if (rsp_tdata !== {1'b0, heading_queue[0]}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("heading mismatch: expected %0d actual %0d",
                        heading_queue[0], rsp_tdata);
            void'(heading_queue.pop_front());
         end else begin
            void'(heading_queue.pop_front());
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   directed_row_type table_rows[$];

   initial begin
      int burst;
      int drain;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      // Level field, no tilt: the heading can be read directly.
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd0, 16'sd0, 16'sd1000}, -1});
      // Zero horizontal vector gives heading zero.
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd0, 16'sd0, 16'sd0}, 0});
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd1234, 16'sd0, 16'sd0}, -1});
      // Negative x with zero y: half a turn.
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd0, 16'sd0, -16'sd1000}, 11520});
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd0, 16'sd1000, 16'sd0}, -1});
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sd0, -16'sd1000, 16'sd0}, -1});
      // Field extremes.
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff}, -1});
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sh8000, 16'sh8000, 16'sh8000}, -1});
      table_rows.push_back('{'{15'sd0, 15'sd0, 16'sh8000, 16'sh7fff, 16'sh8000}, -1});
      // Angles at the limits and past a quarter turn.
      table_rows.push_back('{'{15'sd11520, 15'sd11520, 16'sd300, 16'sd200, 16'sd100}, -1});
      table_rows.push_back('{'{-15'sd11520, -15'sd11520, 16'sd300, 16'sd200, 16'sd100}, -1});
      table_rows.push_back('{'{15'sd5760, 15'sd5761, -16'sd300, 16'sd200, 16'sd900}, -1});
      table_rows.push_back('{'{-15'sd5761, -15'sd5760, 16'sd300, -16'sd200, 16'sd900}, -1});
      table_rows.push_back('{'{15'sd8000, -15'sd9000, 16'sd500, 16'sd700, -16'sd400}, -1});
      // Angles past half a turn, out to the ends of the 15 bit range.
      table_rows.push_back('{'{15'sd11521, -15'sd11521, 16'sd10, 16'sd20, 16'sd30}, -1});
      table_rows.push_back('{'{15'h3fff, 15'h4000, 16'sd4000, -16'sd2000, 16'sd1000}, -1});
      table_rows.push_back('{'{15'h4000, 15'h3fff, -16'sd4000, 16'sd2000, 16'sd1000}, -1});
      table_rows.push_back('{'{15'h7fff, 15'h0001, 16'sh7fff, 16'sh8000, 16'sh7fff}, -1});
      table_rows.push_back('{'{15'h2aaa, 15'h5555, 16'shaaaa, 16'sh5555, 16'shaaaa}, -1});
      table_rows.push_back('{'{15'h5555, 15'h2aaa, 16'sh5555, 16'shaaaa, 16'sh5555}, -1});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].known);
      idle_cycles(1);

      // Hold off until the pipe has fully drained, then start random traffic.
      wait (heading_queue.size() == 0);
      @(posedge clock);

      for (int n = 0; n < RandomReqs; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RandomReqs; b++, n++)
            send_request(random_req(), -1);
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      end
      idle_cycles(1);

      drain = 0;
      while (heading_queue.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (Latency + 10) @(posedge clock);

      if (mismatches == 0 && heading_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
